FILE: rtl/mpq_pkg.sv
// Shared constants, types and helpers for the multilevel priority queue.
package mpq_pkg;

  // Sizing of the queue.
  localparam int MAX_LEVELS  = 8;
  localparam int LEVEL_DEPTH = 16;
  localparam int ID_WIDTH    = 16;

  localparam int PTR_W  = $clog2(LEVEL_DEPTH);
  localparam int FILL_W = $clog2(LEVEL_DEPTH + 1);
  localparam int LIDX_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

  // Fixed field widths on the ports.
  localparam int CMD_W    = 2;
  localparam int PRIO_W   = 4;
  localparam int NLVL_W   = 4;
  localparam int TOTAL_W  = 8;
  localparam int LVLCNT_W = 5;
  localparam int STATUS_W = 2;
  localparam int PORT_ID_W = 16;

  // Input tdata layout: task_id, task_priority.
  localparam int IN_PRIO_LSB  = PORT_ID_W;
  localparam int IN_TDATA_W   = 24;

  // Output tdata layout: head_id, head_priority, all_empty, total_count,
  // level_count, status.
  localparam int OUT_PRIO_LSB   = PORT_ID_W;
  localparam int OUT_EMPTY_BIT  = OUT_PRIO_LSB + PRIO_W;
  localparam int OUT_TOTAL_LSB  = OUT_EMPTY_BIT + 1;
  localparam int OUT_LVLCNT_LSB = OUT_TOTAL_LSB + TOTAL_W;
  localparam int OUT_STATUS_LSB = OUT_LVLCNT_LSB + LVLCNT_W;
  localparam int OUT_USED_W     = OUT_STATUS_LSB + STATUS_W;
  localparam int OUT_TDATA_W    = 40;

  typedef logic [ID_WIDTH-1:0] id_t;
  typedef logic [PTR_W-1:0]    ptr_t;
  typedef logic [FILL_W-1:0]   fill_t;
  typedef logic [LIDX_W-1:0]   lidx_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // Per-level update request.
  typedef struct packed {
    logic push;
    logic pop;
  } lvl_ctrl_t;

  // Per-level state seen by the selection logic.
  typedef struct packed {
    fill_t fill;
    fill_t fill_next;
    id_t   head_id_next;
  } lvl_stat_t;

  // Circular slot advance.
  function automatic ptr_t next_slot(input ptr_t s);
    ptr_t r;
    if (s == ptr_t'(LEVEL_DEPTH - 1)) r = '0;
    else r = s + ptr_t'(1);
    return r;
  endfunction

endpackage

FILE: rtl/mpq_level.sv
// One priority level: a circular FIFO of task ids with its pointers and fill count.
module mpq_level (
  input  logic               clk,
  input  logic               rst,
  input  mpq_pkg::lvl_ctrl_t ctrl,
  input  mpq_pkg::id_t       push_id,
  output mpq_pkg::lvl_stat_t stat
);
  import mpq_pkg::*;

  id_t   slots [LEVEL_DEPTH];
  ptr_t  head, tail, head_next, tail_next;
  fill_t fill, fill_next;

  // Pointer and count updates for this transaction.
  always_comb begin
    head_next = ctrl.pop  ? next_slot(head) : head;
    tail_next = ctrl.push ? next_slot(tail) : tail;
    if (ctrl.push) begin
      fill_next = fill + fill_t'(1);
    end else if (ctrl.pop) begin
      fill_next = fill - fill_t'(1);
    end else begin
      fill_next = fill;
    end
  end

  // Head after the update; an add into an empty level is forwarded.
  always_comb begin
    stat.fill      = fill;
    stat.fill_next = fill_next;
    if (ctrl.push && (tail == head_next)) begin
      stat.head_id_next = push_id;
    end else begin
      stat.head_id_next = slots[head_next];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      head <= head_next;
      tail <= tail_next;
      fill <= fill_next;
    end
  end

  // Task id storage.
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      slots[tail] <= push_id;
    end
  end

endmodule

FILE: rtl/multilevel_priority_queue_top.sv
// Top level of the multilevel strict-priority task queue.
//
//  channel  | signals                         | contents
//  ---------+---------------------------------+--------------------------------------
//  s_       | s_tvalid s_tready s_tdata s_tuser | command: cmd, task_id, task_priority
//  m_       | m_tvalid m_tready m_tdata        | result: head, counts, status
//  cfg_     | cfg_we cfg_wdata                 | num_levels register write
//
// A command lands in the input register when it is accepted; the level update and head
// selection are committed into the result register once that register is free or its
// result is taken, and the result is offered from the result register.
// One command is accepted every cycle while results are taken.
// A stalled result holds the pipeline; the input side stalls only when both
// the input register and the result register are occupied.
// Synchronous reset empties every level and sets num_levels to 8.
module multilevel_priority_queue_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // task_id [15:0], task_priority [19:16], zero [23:20]
  input  logic [mpq_pkg::IN_TDATA_W-1:0]   s_tdata,
  // cmd [1:0]
  input  logic [mpq_pkg::CMD_W-1:0]        s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // head_id [15:0], head_priority [19:16], all_empty [20], total_count [28:21],
  // level_count [33:29], status [35:34], zero [39:36]
  output logic [mpq_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input  logic                             cfg_we,
  input  logic [mpq_pkg::NLVL_W-1:0]       cfg_wdata
);
  import mpq_pkg::*;

  // Configuration.
  logic [NLVL_W-1:0] num_levels;
  logic [NLVL_W-1:0] n_eff;

  // Input register.
  logic                in_valid;
  cmd_e                in_cmd;
  id_t                 in_id;
  logic [PRIO_W-1:0]   in_prio;

  // Result register.
  logic                out_valid;
  id_t                 out_head_id;
  logic [PRIO_W-1:0]   out_head_prio;
  logic                out_empty;
  logic [TOTAL_W-1:0]  out_total;
  logic [LVLCNT_W-1:0] out_lvl_cnt;
  status_e             out_status;

  // Level interface.
  lvl_ctrl_t ctrl [MAX_LEVELS];
  lvl_stat_t stat [MAX_LEVELS];

  // Step logic.
  logic                advance;
  logic                prio_ok;
  lidx_t               prio_idx;
  logic                top_found, top_found_next;
  lidx_t               top_idx, top_idx_next;
  logic                do_push, do_pop;
  status_e             status_next;
  logic [TOTAL_W-1:0]  total_next;
  logic [LVLCNT_W-1:0] lvl_cnt_next;
  id_t                 head_id_next;
  logic [PRIO_W-1:0]   head_prio_next;

  // Handshake.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;

  // Register value 0 acts as one level, values above the maximum as the maximum.
  always_comb begin
    if (num_levels == '0) begin
      n_eff = NLVL_W'(1);
    end else if (num_levels > NLVL_W'(MAX_LEVELS)) begin
      n_eff = NLVL_W'(MAX_LEVELS);
    end else begin
      n_eff = num_levels;
    end
  end

  // Requested level check.
  assign prio_ok  = (in_prio >= PRIO_W'(1)) && (in_prio <= PRIO_W'(n_eff));
  assign prio_idx = LIDX_W'(in_prio - PRIO_W'(1));

  // Highest non-empty level before the update.
  always_comb begin
    top_found = 1'b0;
    top_idx   = '0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if ((stat[i].fill != '0) && (i < int'(n_eff))) begin
        top_found = 1'b1;
        top_idx   = LIDX_W'(i);
      end
    end
  end

  // Command decode and status.
  always_comb begin
    do_push     = 1'b0;
    do_pop      = 1'b0;
    status_next = ST_OK;
    case (in_cmd)
      CMD_ADD: begin
        if (!prio_ok) begin
          status_next = ST_RANGE;
        end else if (stat[prio_idx].fill >= fill_t'(LEVEL_DEPTH)) begin
          status_next = ST_FULL;
        end else begin
          do_push = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (!top_found) begin
          status_next = ST_EMPTY;
        end else begin
          do_pop = 1'b1;
        end
      end
      default: begin
        if (!prio_ok) status_next = ST_RANGE;
      end
    endcase
  end

  // Per-level requests, only on a committed transaction.
  always_comb begin
    for (int i = 0; i < MAX_LEVELS; i++) begin
      ctrl[i].push = advance && do_push && (prio_idx == LIDX_W'(i));
      ctrl[i].pop  = advance && do_pop && (top_idx == LIDX_W'(i));
    end
  end

  // Levels.
  for (genvar g = 0; g < MAX_LEVELS; g++) begin : g_level
    mpq_level u_level (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl[g]),
      .push_id (in_id),
      .stat    (stat[g])
    );
  end

  // State after the update: highest head, total and requested count.
  always_comb begin
    top_found_next = 1'b0;
    top_idx_next   = '0;
    total_next     = '0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if (i < int'(n_eff)) begin
        total_next = total_next + TOTAL_W'(stat[i].fill_next);
        if (stat[i].fill_next != '0) begin
          top_found_next = 1'b1;
          top_idx_next   = LIDX_W'(i);
        end
      end
    end
    if (top_found_next) begin
      head_id_next   = stat[top_idx_next].head_id_next;
      head_prio_next = PRIO_W'(top_idx_next) + PRIO_W'(1);
    end else begin
      head_id_next   = '0;
      head_prio_next = '0;
    end
    lvl_cnt_next = prio_ok ? LVLCNT_W'(stat[prio_idx].fill_next) : '0;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_levels <= NLVL_W'(MAX_LEVELS);
      in_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) num_levels <= cfg_wdata;
      if (s_tready) in_valid <= s_tvalid;
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd  <= cmd_e'(s_tuser);
      in_id   <= id_t'(s_tdata[PORT_ID_W-1:0]);
      in_prio <= s_tdata[IN_PRIO_LSB +: PRIO_W];
    end
    if (advance) begin
      out_head_id   <= head_id_next;
      out_head_prio <= head_prio_next;
      out_empty     <= !top_found_next;
      out_total     <= total_next;
      out_lvl_cnt   <= lvl_cnt_next;
      out_status    <= status_next;
    end
  end

  // Result packing.
  assign m_tdata = {(OUT_TDATA_W - OUT_USED_W)'(0), out_status, out_lvl_cnt, out_total,
                    out_empty, out_head_prio, PORT_ID_W'(out_head_id)};

endmodule

FILE: rtl/mpq_checker.sv
// Port-level checks on the multilevel priority queue, bound to its top level.
module mpq_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [mpq_pkg::OUT_TDATA_W-1:0]  m_tdata
);
  import mpq_pkg::*;

  logic [PRIO_W-1:0]   r_prio;
  logic                r_empty;
  logic [TOTAL_W-1:0]  r_total;
  logic [LVLCNT_W-1:0] r_lvl_cnt;
  logic [STATUS_W-1:0] r_status;

  // Result field unpacking.
  assign r_prio    = m_tdata[OUT_PRIO_LSB +: PRIO_W];
  assign r_empty   = m_tdata[OUT_EMPTY_BIT];
  assign r_total   = m_tdata[OUT_TOTAL_LSB +: TOTAL_W];
  assign r_lvl_cnt = m_tdata[OUT_LVLCNT_LSB +: LVLCNT_W];
  assign r_status  = m_tdata[OUT_STATUS_LSB +: STATUS_W];

  // A stalled result holds its transaction.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // The empty flag agrees with the head level and the total.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (r_empty == (r_total == '0)) && (r_empty == (r_prio == '0)))
    else $error("empty flag inconsistent with head level or total");

  // A full level reports a full count.
  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (r_status == ST_FULL) |-> (r_lvl_cnt == LVLCNT_W'(LEVEL_DEPTH)))
    else $error("full status without a full level count");

  // An out-of-range level reports no tasks.
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (r_status == ST_RANGE) |-> (r_lvl_cnt == '0))
    else $error("out-of-range level with nonzero count");

  // A failed remove means the store was and stays empty.
  a_rm_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (r_status == ST_EMPTY) |-> r_empty)
    else $error("remove-from-empty status with tasks held");

endmodule

bind multilevel_priority_queue_top mpq_checker u_mpq_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
